@@ src/swl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package swl_pkg;

  // lap memory depth
  localparam int MAX_LAPS  = 8;
  localparam int LAP_CNT_W = $clog2(MAX_LAPS + 1);
  localparam int LAP_IDX_W = (MAX_LAPS > 1) ? $clog2(MAX_LAPS) : 1;

  // payload widths
  localparam int OP_W    = 2;
  localparam int SEL_W   = 3;
  localparam int HELD_W  = 4;
  localparam int MIN_W   = 17;
  localparam int SEC_W   = 6;
  localparam int CENTI_W = 7;
  localparam int UNIT_W  = 4;
  localparam int RAW_W   = 32;

  // common width for lap index compares
  localparam int LAP_CMP_W = (LAP_CNT_W > SEL_W + 1) ? LAP_CNT_W : SEL_W + 1;

  // op codes
  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_LAP   = 2'd2;
  localparam logic [OP_W-1:0] OP_READ  = 2'd3;

  // digit limits of the cascaded counter
  localparam logic [UNIT_W-1:0]  UNIT_LAST  = 4'd9;
  localparam logic [CENTI_W-1:0] CENTI_LAST = 7'd99;
  localparam logic [SEC_W-1:0]   SEC_LAST   = 6'd59;

  typedef struct packed {
    logic [MIN_W-1:0]   minutes;
    logic [SEC_W-1:0]   seconds;
    logic [CENTI_W-1:0] centis;
  } time_t;

  typedef struct packed {
    logic inc;
    logic clr;
  } cnt_ctrl_t;

  typedef struct packed {
    logic wr;
    logic clr;
  } lap_ctrl_t;

  typedef struct packed {
    time_t split;
    time_t total;
  } lap_entry_t;

  typedef struct packed {
    logic              running;
    logic [HELD_W-1:0] laps_held;
    time_t             now;
    logic              lap_valid;
    lap_entry_t        lap;
  } result_t;

endpackage

`default_nettype wire

@@ src/swl_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface swl_in_if;
  logic                       valid;
  logic                       ready;
  logic [swl_pkg::OP_W-1:0]   op;
  logic [swl_pkg::SEL_W-1:0]  lap_select;

  modport source (output valid, output op, output lap_select, input ready);
  modport sink   (input valid, input op, input lap_select, output ready);
endinterface

interface swl_out_if;
  logic                         valid;
  logic                         ready;
  logic                         running;
  logic [swl_pkg::HELD_W-1:0]   laps_held;
  logic [swl_pkg::MIN_W-1:0]    time_minutes;
  logic [swl_pkg::SEC_W-1:0]    time_seconds;
  logic [swl_pkg::CENTI_W-1:0]  time_centis;
  logic                         lap_valid;
  logic [swl_pkg::MIN_W-1:0]    split_minutes;
  logic [swl_pkg::SEC_W-1:0]    split_seconds;
  logic [swl_pkg::CENTI_W-1:0]  split_centis;
  logic [swl_pkg::MIN_W-1:0]    total_minutes;
  logic [swl_pkg::SEC_W-1:0]    total_seconds;
  logic [swl_pkg::CENTI_W-1:0]  total_centis;

  modport source (
    output valid, output running, output laps_held,
    output time_minutes, output time_seconds, output time_centis,
    output lap_valid,
    output split_minutes, output split_seconds, output split_centis,
    output total_minutes, output total_seconds, output total_centis,
    input ready
  );
  modport sink (
    input valid, input running, input laps_held,
    input time_minutes, input time_seconds, input time_centis,
    input lap_valid,
    input split_minutes, input split_seconds, input split_centis,
    input total_minutes, input total_seconds, input total_centis,
    output ready
  );
endinterface

`default_nettype wire

@@ src/swl_time_cnt.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Cascaded ms / centi / second / minute counter with a raw 32-bit shadow
// that detects the 2^32 ms wrap.
module swl_time_cnt (
  input  wire                  clk,
  input  wire                  rst_n,
  input  swl_pkg::cnt_ctrl_t   ctrl,
  output swl_pkg::time_t       cur,
  output swl_pkg::time_t       nxt
);

  logic [swl_pkg::UNIT_W-1:0]  unit_r,  unit_nxt;
  logic [swl_pkg::CENTI_W-1:0] centi_r, centi_nxt;
  logic [swl_pkg::SEC_W-1:0]   sec_r,   sec_nxt;
  logic [swl_pkg::MIN_W-1:0]   min_r,   min_nxt;
  logic [swl_pkg::RAW_W-1:0]   raw_r,   raw_nxt;

  always_comb begin
    unit_nxt  = unit_r;
    centi_nxt = centi_r;
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    raw_nxt   = raw_r;
    if (ctrl.clr || (ctrl.inc && (&raw_r))) begin
      // clear, or wrap past 2^32 - 1 ms
      unit_nxt  = '0;
      centi_nxt = '0;
      sec_nxt   = '0;
      min_nxt   = '0;
      raw_nxt   = '0;
    end else if (ctrl.inc) begin
      raw_nxt = raw_r + 1'b1;
      if (unit_r != swl_pkg::UNIT_LAST) begin
        unit_nxt = unit_r + 1'b1;
      end else begin
        unit_nxt = '0;
        if (centi_r != swl_pkg::CENTI_LAST) begin
          centi_nxt = centi_r + 1'b1;
        end else begin
          centi_nxt = '0;
          if (sec_r != swl_pkg::SEC_LAST) begin
            sec_nxt = sec_r + 1'b1;
          end else begin
            sec_nxt = '0;
            min_nxt = min_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r  <= '0;
      centi_r <= '0;
      sec_r   <= '0;
      min_r   <= '0;
      raw_r   <= '0;
    end else begin
      unit_r  <= unit_nxt;
      centi_r <= centi_nxt;
      sec_r   <= sec_nxt;
      min_r   <= min_nxt;
      raw_r   <= raw_nxt;
    end
  end

  assign cur.minutes = min_r;
  assign cur.seconds = sec_r;
  assign cur.centis  = centi_r;
  assign nxt.minutes = min_nxt;
  assign nxt.seconds = sec_nxt;
  assign nxt.centis  = centi_nxt;

endmodule

`default_nettype wire

@@ src/swl_lap_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Lap memory: entries at or above the lap count are never read, so a
// clear only drops the count.
module swl_lap_store (
  input  wire                           clk,
  input  wire                           rst_n,
  input  swl_pkg::lap_ctrl_t            ctrl,
  input  swl_pkg::lap_entry_t           wr_entry,
  input  wire [swl_pkg::SEL_W-1:0]      rd_sel,
  output logic                          full,
  output logic                          rd_hit,
  output swl_pkg::lap_entry_t           rd_entry,
  output logic [swl_pkg::HELD_W-1:0]    held_nxt,
  output logic [swl_pkg::LAP_CNT_W-1:0] count
);

  swl_pkg::lap_entry_t            mem_r [swl_pkg::MAX_LAPS];
  logic [swl_pkg::LAP_CNT_W-1:0]  count_r, count_nxt;
  logic [swl_pkg::LAP_CMP_W-1:0]  sel_ext, cnt_ext, max_ext;

  assign full    = (count_r == swl_pkg::LAP_CNT_W'(swl_pkg::MAX_LAPS));
  assign sel_ext = swl_pkg::LAP_CMP_W'(rd_sel);
  assign cnt_ext = swl_pkg::LAP_CMP_W'(count_r);
  assign max_ext = swl_pkg::LAP_CMP_W'(swl_pkg::MAX_LAPS);
  assign rd_hit  = (sel_ext < cnt_ext) && (sel_ext < max_ext);
  assign rd_entry = mem_r[swl_pkg::LAP_IDX_W'(rd_sel)];

  always_comb begin
    count_nxt = count_r;
    if (ctrl.clr) begin
      count_nxt = '0;
    end else if (ctrl.wr && !full) begin
      count_nxt = count_r + 1'b1;
    end
  end

  assign held_nxt = swl_pkg::HELD_W'(count_nxt);
  assign count    = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr && !full) begin
      mem_r[count_r[swl_pkg::LAP_IDX_W-1:0]] <= wr_entry;
    end
  end

endmodule

`default_nettype wire

@@ src/stopwatch_lap_timer_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir   Modport  Word
// in_if     in    sink     op, lap_select
// out_if    out   source   running, laps_held, time_*, lap_valid, split_*, total_*
//
// One word in per cycle while in_if.ready is high, one result word per input word.
// State (run flag, time counters, lap memory) updates at the accepting edge;
// the result is built from that state by short logic and registered.
// Result register plus skid: in_if.ready drops only while the skid holds a word.
// Synchronous active-low reset clears run flag, time, lap count and output
// stage; laps at or above the count are never read, so no clearing pass.
module stopwatch_lap_timer_top (
  input  wire        clk,
  input  wire        rst_n,
  swl_in_if.sink     in_if,
  swl_out_if.source  out_if
);

  logic                 accept;
  logic                 counting_r, counting_nxt;
  logic                 do_tick, do_clear, do_record, do_read;
  swl_pkg::cnt_ctrl_t   elapsed_ctrl, split_ctrl;
  swl_pkg::lap_ctrl_t   lap_ctrl;
  swl_pkg::time_t       elapsed_cur, elapsed_nxt, split_cur, split_nxt;
  swl_pkg::lap_entry_t  rec_entry, rd_entry;
  logic                 full, rd_hit;
  logic [swl_pkg::HELD_W-1:0]    held_nxt;
  logic [swl_pkg::LAP_CNT_W-1:0] lap_count;
  swl_pkg::result_t     res;

  swl_pkg::result_t     out_r, skid_r;
  logic                 out_valid_r, skid_valid_r;

  assign in_if.ready = !skid_valid_r;
  assign accept      = in_if.valid && in_if.ready;

  // decode the word into one action
  always_comb begin
    do_tick      = 1'b0;
    do_clear     = 1'b0;
    do_record    = 1'b0;
    do_read      = 1'b0;
    counting_nxt = counting_r;
    if (accept) begin
      case (in_if.op)
        swl_pkg::OP_TICK:  do_tick = counting_r;
        swl_pkg::OP_START: counting_nxt = !counting_r;
        swl_pkg::OP_LAP: begin
          // lap while running and not full, full clear while paused
          do_record = counting_r && !full;
          do_clear  = !counting_r;
        end
        swl_pkg::OP_READ:  do_read = rd_hit;
        default: ;
      endcase
    end
  end

  assign elapsed_ctrl.inc = do_tick;
  assign elapsed_ctrl.clr = do_clear;
  // split counter restarts at every recorded lap
  assign split_ctrl.inc   = do_tick;
  assign split_ctrl.clr   = do_clear || do_record;
  assign lap_ctrl.wr      = do_record;
  assign lap_ctrl.clr     = do_clear;

  swl_time_cnt u_elapsed (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (elapsed_ctrl),
    .cur   (elapsed_cur),
    .nxt   (elapsed_nxt)
  );

  swl_time_cnt u_split (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (split_ctrl),
    .cur   (split_cur),
    .nxt   (split_nxt)
  );

  assign rec_entry.split = split_cur;
  assign rec_entry.total = elapsed_cur;

  swl_lap_store u_laps (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (lap_ctrl),
    .wr_entry (rec_entry),
    .rd_sel   (in_if.lap_select),
    .full     (full),
    .rd_hit   (rd_hit),
    .rd_entry (rd_entry),
    .held_nxt (held_nxt),
    .count    (lap_count)
  );

  // build the result word from the post-item state
  always_comb begin
    res.running   = counting_nxt;
    res.laps_held = held_nxt;
    res.now       = elapsed_nxt;
    res.lap_valid = do_record || do_read;
    if (do_record) begin
      res.lap = rec_entry;
    end else if (do_read) begin
      res.lap = rd_entry;
    end else begin
      res.lap = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counting_r <= 1'b0;
    end else begin
      counting_r <= counting_nxt;
    end
  end

  // output register plus skid: park a word in skid when the sink stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_if.ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_if.ready) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (accept) begin
        out_r <= res;
      end
    end else if (accept) begin
      skid_r <= res;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.running       = out_r.running;
  assign out_if.laps_held     = out_r.laps_held;
  assign out_if.time_minutes  = out_r.now.minutes;
  assign out_if.time_seconds  = out_r.now.seconds;
  assign out_if.time_centis   = out_r.now.centis;
  assign out_if.lap_valid     = out_r.lap_valid;
  assign out_if.split_minutes = out_r.lap.split.minutes;
  assign out_if.split_seconds = out_r.lap.split.seconds;
  assign out_if.split_centis  = out_r.lap.split.centis;
  assign out_if.total_minutes = out_r.lap.total.minutes;
  assign out_if.total_seconds = out_r.lap.total.seconds;
  assign out_if.total_centis  = out_r.lap.total.centis;

  // skid holds a word only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid valid without output valid");

  // no lap in the word means zero split and total
  a_lap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.lap_valid) |-> (out_r.lap == '0))
    else $error("lap fields set without lap_valid");

  // counter digits stay in range
  a_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.now.seconds <= swl_pkg::SEC_LAST &&
                     out_r.now.centis <= swl_pkg::CENTI_LAST))
    else $error("time digit out of range");

  // lap count never passes the memory depth
  a_lap_count: assert property (@(posedge clk) disable iff (!rst_n)
    lap_count <= swl_pkg::LAP_CNT_W'(swl_pkg::MAX_LAPS))
    else $error("lap count beyond depth");

  // a recorded lap bumps the count by one
  a_record_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_record |=> (lap_count == $past(lap_count) + 1'b1))
    else $error("lap record did not advance count");

endmodule

`default_nettype wire
